// File: rtl/dwpid_pkg.sv
`default_nettype none
package dwpid_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_DUTY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KP_LEFT      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KI_LEFT      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KD_LEFT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_KP_RIGHT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_KI_RIGHT     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_KD_RIGHT     = 3'd7;

  // Register reset values.
  localparam logic [14:0] TARGET_SPEED_RST = 15'd5120;
  localparam logic [15:0] BASE_DUTY_RST    = 16'd32768;
  localparam logic [23:0] KP_LEFT_RST      = 24'd1677722;
  localparam logic [23:0] KI_LEFT_RST      = 24'd167772;
  localparam logic [23:0] KD_LEFT_RST      = 24'd1678;
  localparam logic [23:0] KP_RIGHT_RST     = 24'd1090519;
  localparam logic [23:0] KI_RIGHT_RST     = 24'd167772;
  localparam logic [23:0] KD_RIGHT_RST     = 24'd1678;

  // Arithmetic constants (Q8.8 and Q0.16).
  localparam logic signed [17:0] INT_LIMIT     = 18'sd25600;
  localparam logic signed [17:0] INT_LIMIT_NEG = -18'sd25600;
  localparam logic [15:0]        DIST_THRESH   = 16'd17920;
  localparam logic [17:0]        DUTY_MIN      = 18'd39322;
  localparam logic [17:0]        DUTY_MAX      = 18'd62259;
  localparam logic [16:0]        FACTOR_ONE    = 17'd65536;
  // floor(2^32 / 70), reciprocal for the distance division.
  localparam logic [25:0]        RECIP_70      = 26'd61356675;
  localparam logic [23:0]        DIV_70        = 24'd70;

  typedef struct packed {
    logic [14:0] target_speed;
    logic [15:0] base_duty;
    logic [23:0] kp_left;
    logic [23:0] ki_left;
    logic [23:0] kd_left;
    logic [23:0] kp_rt;
    logic [23:0] ki_rt;
    logic [23:0] kd_rt;
  } cfg_t;

  // Operand selection for the shared multiplier.
  typedef enum logic [3:0] {
    MUL_FACTOR,
    MUL_KP_L,
    MUL_KI_L,
    MUL_KD_L,
    MUL_KP_R,
    MUL_KI_R,
    MUL_KD_R,
    MUL_SCALE_L,
    MUL_SCALE_R
  } mul_op_t;

  // Control-sum accumulator operations.
  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_LOAD_L,
    ACC_ADD_L,
    ACC_LOAD_R,
    ACC_ADD_R
  } acc_op_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic    capture;
    mul_op_t mul_op;
    logic    factor_ld;
    acc_op_t acc_op;
    logic    level_l_ld;
    logic    level_r_ld;
    logic    out_ld;
  } dp_cmd_t;

endpackage
`default_nettype wire

// File: rtl/dual_wheel_pid_duty_controller.sv
// One request is worked on at a time: the input stalls until the sequencer is idle again.
// An enabled request runs through the nine products of the one shared multiplier
// (distance reciprocal, six gains, two duty scalings); a disabled one skips them.
// A finished result waits in an output register; the next request is taken meanwhile.
// Reset (rst, synchronous, active high) restores the register defaults and clears the
// integrals and last errors of both wheels.
`default_nettype none
module dual_wheel_pid_duty_controller (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic signed [15:0]                left_speed,
  input  wire logic signed [15:0]                right_speed,
  input  wire logic [15:0]                       obstacle_distance,
  input  wire logic                              control_enable,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [15:0]                            left_level,
  output logic [15:0]                            right_level,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [dwpid_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dwpid_pkg::CFG_DATA_W-1:0]  cfg_data
);

  dwpid_pkg::cfg_t    cfg;
  dwpid_pkg::dp_cmd_t cmd;

  // Configuration registers.
  dwpid_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Sequencer.
  dwpid_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .control_enable (control_enable),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .cmd            (cmd)
  );

  // Arithmetic and PID state.
  dwpid_datapath u_dp (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .cfg               (cfg),
    .left_speed        (left_speed),
    .right_speed       (right_speed),
    .obstacle_distance (obstacle_distance),
    .control_enable    (control_enable),
    .left_level        (left_level),
    .right_level       (right_level)
  );

endmodule
`default_nettype wire

// File: rtl/dwpid_cfg.sv
`default_nettype none
module dwpid_cfg (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dwpid_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dwpid_pkg::CFG_DATA_W-1:0]    cfg_data,
  output dwpid_pkg::cfg_t                          cfg
);

  // Writes must be issued while the block is idle (not enforced); ready is tied high.
  assign cfg_ready = 1'b1;

  // Register file with reset values; data is masked to each field width.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.target_speed <= dwpid_pkg::TARGET_SPEED_RST;
      cfg.base_duty    <= dwpid_pkg::BASE_DUTY_RST;
      cfg.kp_left      <= dwpid_pkg::KP_LEFT_RST;
      cfg.ki_left      <= dwpid_pkg::KI_LEFT_RST;
      cfg.kd_left      <= dwpid_pkg::KD_LEFT_RST;
      cfg.kp_rt        <= dwpid_pkg::KP_RIGHT_RST;
      cfg.ki_rt        <= dwpid_pkg::KI_RIGHT_RST;
      cfg.kd_rt        <= dwpid_pkg::KD_RIGHT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dwpid_pkg::REG_TARGET_SPEED: cfg.target_speed <= cfg_data[14:0];
        dwpid_pkg::REG_BASE_DUTY:    cfg.base_duty    <= cfg_data[15:0];
        dwpid_pkg::REG_KP_LEFT:      cfg.kp_left      <= cfg_data;
        dwpid_pkg::REG_KI_LEFT:      cfg.ki_left      <= cfg_data;
        dwpid_pkg::REG_KD_LEFT:      cfg.kd_left      <= cfg_data;
        dwpid_pkg::REG_KP_RIGHT:     cfg.kp_rt        <= cfg_data;
        dwpid_pkg::REG_KI_RIGHT:     cfg.ki_rt        <= cfg_data;
        dwpid_pkg::REG_KD_RIGHT:     cfg.kd_rt        <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/dwpid_datapath.sv
`default_nettype none
module dwpid_datapath (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire dwpid_pkg::dp_cmd_t cmd,
  input  wire dwpid_pkg::cfg_t    cfg,
  input  wire logic signed [15:0] left_speed,
  input  wire logic signed [15:0] right_speed,
  input  wire logic [15:0]        obstacle_distance,
  input  wire logic               control_enable,
  output logic [15:0]             left_level,
  output logic [15:0]             right_level
);

  typedef struct packed {
    logic signed [16:0] err;
    logic signed [15:0] integ;
    logic signed [17:0] der;
  } pid_t;

  // One PID state update: error, clamped integral and derivative, all zero unless the speed is positive.
  function automatic pid_t pid_update(input logic signed [15:0] spd,
                                      input logic [14:0] tgt,
                                      input logic signed [15:0] integ,
                                      input logic signed [16:0] last);
    pid_t               r;
    logic signed [16:0] err;
    logic signed [17:0] sum;
    err = $signed({2'b00, tgt}) - $signed({spd[15], spd});
    sum = $signed({integ[15], integ[15], integ}) + $signed({err[16], err});
    r = '0;
    if (!spd[15] && (spd != 16'sd0)) begin
      r.err = err;
      if (sum > dwpid_pkg::INT_LIMIT) begin
        r.integ = dwpid_pkg::INT_LIMIT[15:0];
      end else if (sum < dwpid_pkg::INT_LIMIT_NEG) begin
        r.integ = dwpid_pkg::INT_LIMIT_NEG[15:0];
      end else begin
        r.integ = sum[15:0];
      end
      r.der = $signed({err[16], err}) - $signed({last[16], last});
    end
    return r;
  endfunction

  // Saturate base duty plus control to the 33-bit range that the scaler needs.
  function automatic logic [32:0] duty_sum(input logic [15:0] base,
                                           input logic signed [44:0] ctl);
    logic signed [45:0] sum;
    logic [32:0]        r;
    sum = $signed({14'b0, base, 16'b0}) + $signed({ctl[44], ctl});
    if (sum[45]) begin
      r = '0;
    end else if (|sum[44:33]) begin
      r = '1;
    end else begin
      r = sum[32:0];
    end
    return r;
  endfunction

  // Clamp the scaled duty to its range and turn it into a compare level.
  function automatic logic [15:0] to_level(input logic [17:0] d);
    logic [17:0] c;
    if (d < dwpid_pkg::DUTY_MIN) begin
      c = dwpid_pkg::DUTY_MIN;
    end else if (d > dwpid_pkg::DUTY_MAX) begin
      c = dwpid_pkg::DUTY_MAX;
    end else begin
      c = d;
    end
    // floor(d * 65535 / 65536) is d - 1 for any non-zero 16-bit duty.
    return c[15:0] - 16'd1;
  endfunction

  // PID state.
  logic signed [15:0] left_integral;
  logic signed [15:0] right_integral;
  logic signed [16:0] left_last_error;
  logic signed [16:0] right_last_error;

  // Per-request working registers.
  logic signed [16:0] err_l, err_r;
  logic signed [17:0] der_l, der_r;
  logic [15:0]        obst_dist;
  logic [16:0]        factor;
  logic signed [44:0] acc_l, acc_r;
  logic [32:0]        sat_l, sat_r;
  logic [15:0]        level_l, level_r;
  logic signed [60:0] prod;

  pid_t               pid_l, pid_r;
  logic signed [33:0] mul_a;
  logic signed [26:0] mul_b;
  logic [23:0]        dist_x;
  logic [17:0]        quot0;
  logic [23:0]        rem;
  logic [17:0]        quot;
  logic [16:0]        factor_next;

  assign pid_l = pid_update(left_speed, cfg.target_speed, left_integral, left_last_error);
  assign pid_r = pid_update(right_speed, cfg.target_speed, right_integral, right_last_error);

  // PID state updates on an enabled request only.
  always_ff @(posedge clk) begin
    if (rst) begin
      left_integral    <= '0;
      right_integral   <= '0;
      left_last_error  <= '0;
      right_last_error <= '0;
    end else if (cmd.capture && control_enable) begin
      left_integral    <= pid_l.integ;
      right_integral   <= pid_r.integ;
      left_last_error  <= pid_l.err;
      right_last_error <= pid_r.err;
    end
  end

  // Capture the error terms and the distance.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      err_l     <= pid_l.err;
      der_l     <= pid_l.der;
      err_r     <= pid_r.err;
      der_r     <= pid_r.der;
      obst_dist <= obstacle_distance;
    end
  end

  // Shared multiplier operand selection.
  assign dist_x = {obst_dist, 8'b0};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.mul_op)
      dwpid_pkg::MUL_FACTOR: begin
        mul_a = $signed({10'b0, dist_x});
        mul_b = $signed({1'b0, dwpid_pkg::RECIP_70});
      end
      dwpid_pkg::MUL_KP_L: begin
        mul_a = 34'(err_l);
        mul_b = $signed({3'b0, cfg.kp_left});
      end
      dwpid_pkg::MUL_KI_L: begin
        mul_a = 34'(left_integral);
        mul_b = $signed({3'b0, cfg.ki_left});
      end
      dwpid_pkg::MUL_KD_L: begin
        mul_a = 34'(der_l);
        mul_b = $signed({3'b0, cfg.kd_left});
      end
      dwpid_pkg::MUL_KP_R: begin
        mul_a = 34'(err_r);
        mul_b = $signed({3'b0, cfg.kp_rt});
      end
      dwpid_pkg::MUL_KI_R: begin
        mul_a = 34'(right_integral);
        mul_b = $signed({3'b0, cfg.ki_rt});
      end
      dwpid_pkg::MUL_KD_R: begin
        mul_a = 34'(der_r);
        mul_b = $signed({3'b0, cfg.kd_rt});
      end
      dwpid_pkg::MUL_SCALE_L: begin
        mul_a = $signed({1'b0, sat_l});
        mul_b = $signed({10'b0, factor});
      end
      dwpid_pkg::MUL_SCALE_R: begin
        mul_a = $signed({1'b0, sat_r});
        mul_b = $signed({10'b0, factor});
      end
      default: begin
      end
    endcase
  end

  // Registered product.
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Speed factor: one from the threshold up, else reciprocal quotient, one correction, then floor.
  always_comb begin
    quot0 = prod[49:32];
    rem   = dist_x - ({6'b0, quot0} * dwpid_pkg::DIV_70);
    quot  = (rem >= dwpid_pkg::DIV_70) ? quot0 + 18'd1 : quot0;
    if (obst_dist >= dwpid_pkg::DIST_THRESH) begin
      factor_next = dwpid_pkg::FACTOR_ONE;
    end else if (quot < dwpid_pkg::DUTY_MIN) begin
      factor_next = dwpid_pkg::DUTY_MIN[16:0];
    end else begin
      factor_next = quot[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.factor_ld) begin
      factor <= factor_next;
    end
  end

  // Control-sum accumulators.
  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      dwpid_pkg::ACC_LOAD_L: acc_l <= prod[44:0];
      dwpid_pkg::ACC_ADD_L:  acc_l <= acc_l + prod[44:0];
      dwpid_pkg::ACC_LOAD_R: acc_r <= prod[44:0];
      dwpid_pkg::ACC_ADD_R:  acc_r <= acc_r + prod[44:0];
      default: begin
      end
    endcase
  end

  // Saturated duty sums, refreshed every cycle from the accumulators.
  always_ff @(posedge clk) begin
    sat_l <= duty_sum(cfg.base_duty, acc_l);
    sat_r <= duty_sum(cfg.base_duty, acc_r);
  end

  // Levels: zero on a disabled request, otherwise from the scaled duty.
  always_ff @(posedge clk) begin
    if (cmd.capture && !control_enable) begin
      level_l <= '0;
      level_r <= '0;
    end else begin
      if (cmd.level_l_ld) begin
        level_l <= to_level(prod[49:32]);
      end
      if (cmd.level_r_ld) begin
        level_r <= to_level(prod[49:32]);
      end
    end
  end

  // Output register, kept apart from the working levels.
  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      left_level  <= level_l;
      right_level <= level_r;
    end
  end

endmodule
`default_nettype wire

// File: rtl/dwpid_ctrl.sv
`default_nettype none
module dwpid_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic           control_enable,
  output logic                out_valid,
  input  wire logic           out_stall,
  output dwpid_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_DONE
  } state_t;

  localparam logic [3:0] LAST_STEP = 4'd10;

  state_t     state;
  logic [3:0] step;

  assign in_stall = (state != ST_IDLE);

  // Command decode: the step schedule of the shared multiplier.
  always_comb begin
    cmd            = '0;
    cmd.mul_op     = dwpid_pkg::MUL_FACTOR;
    cmd.acc_op     = dwpid_pkg::ACC_HOLD;
    cmd.capture    = in_valid && !in_stall;
    cmd.out_ld     = (state == ST_DONE) && (!out_valid || !out_stall);
    if (state == ST_CALC) begin
      case (step)
        4'd0: cmd.mul_op = dwpid_pkg::MUL_FACTOR;
        4'd1: begin
          cmd.mul_op    = dwpid_pkg::MUL_KP_L;
          cmd.factor_ld = 1'b1;
        end
        4'd2: begin
          cmd.mul_op = dwpid_pkg::MUL_KI_L;
          cmd.acc_op = dwpid_pkg::ACC_LOAD_L;
        end
        4'd3: begin
          cmd.mul_op = dwpid_pkg::MUL_KD_L;
          cmd.acc_op = dwpid_pkg::ACC_ADD_L;
        end
        4'd4: begin
          cmd.mul_op = dwpid_pkg::MUL_KP_R;
          cmd.acc_op = dwpid_pkg::ACC_ADD_L;
        end
        4'd5: begin
          cmd.mul_op = dwpid_pkg::MUL_KI_R;
          cmd.acc_op = dwpid_pkg::ACC_LOAD_R;
        end
        4'd6: begin
          cmd.mul_op = dwpid_pkg::MUL_KD_R;
          cmd.acc_op = dwpid_pkg::ACC_ADD_R;
        end
        4'd7: begin
          cmd.mul_op = dwpid_pkg::MUL_SCALE_L;
          cmd.acc_op = dwpid_pkg::ACC_ADD_R;
        end
        4'd8: begin
          // This product is discarded while the right duty sum settles.
          cmd.mul_op     = dwpid_pkg::MUL_SCALE_R;
          cmd.level_l_ld = 1'b1;
        end
        4'd9: cmd.mul_op = dwpid_pkg::MUL_SCALE_R;
        4'd10: cmd.level_r_ld = 1'b1;
        default: begin
        end
      endcase
    end
  end

  // Sequencer state, step count and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.out_ld) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (cmd.capture) begin
            state <= control_enable ? ST_CALC : ST_DONE;
            step  <= '0;
          end
        end
        ST_CALC: begin
          if (step == LAST_STEP) begin
            state <= ST_DONE;
          end else begin
            step <= step + 4'd1;
          end
        end
        ST_DONE: begin
          if (cmd.out_ld) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A new request is only taken with the sequencer idle.
  a_capture_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> state == ST_IDLE)
    else $error("request captured while busy");

  // The step count never runs past the end of the schedule.
  a_step_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_CALC |-> step <= LAST_STEP)
    else $error("step count out of range");

  // A result only appears after the sequencer has finished.
  a_valid_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result shown without a finished request");

  // Loading the output returns the sequencer to idle with a valid result.
  a_done_to_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_ld |=> state == ST_IDLE && out_valid)
    else $error("output load did not complete");

endmodule
`default_nettype wire

// File: verif/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 16;
  localparam int LIMIT_CYCLES  = 500000;
  localparam int IDLE_PERCENT  = 19;

  // One control tick as offered on the request channel.
  typedef struct {
    logic signed [15:0] lspd;
    logic signed [15:0] rspd;
    logic [15:0]        obst;
    logic               en;
  } tick_t;

  // The pair of PWM levels that one tick yields.
  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
  } levels_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;
  logic [15:0] obstacle_distance;
  logic control_enable;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [15:0] left_level;
  logic [15:0] right_level;
  logic cfg_valid;
  logic cfg_ready;
  logic [dwpid_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dwpid_pkg::CFG_DATA_W-1:0] cfg_data;

  dual_wheel_pid_duty_controller u_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .left_speed        (left_speed),
    .right_speed       (right_speed),
    .obstacle_distance (obstacle_distance),
    .control_enable    (control_enable),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .left_level        (left_level),
    .right_level       (right_level),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the controller's registers and PID state.
  logic [14:0] target_q;
  logic [15:0] base_q;
  logic [23:0] kp_q [2];
  logic [23:0] ki_q [2];
  logic [23:0] kd_q [2];
  int          integ_st [2];
  int          last_err_st [2];

  levels_t expected_levels [$];
  levels_t next_levels;
  int      mismatches = 0;
  int      cycle_count = 0;
  bit      no_idle = 1'b0;

  function automatic void reset_shadow();
    target_q = dwpid_pkg::TARGET_SPEED_RST;
    base_q   = dwpid_pkg::BASE_DUTY_RST;
    kp_q[0]  = dwpid_pkg::KP_LEFT_RST;
    ki_q[0]  = dwpid_pkg::KI_LEFT_RST;
    kd_q[0]  = dwpid_pkg::KD_LEFT_RST;
    kp_q[1]  = dwpid_pkg::KP_RIGHT_RST;
    ki_q[1]  = dwpid_pkg::KI_RIGHT_RST;
    kd_q[1]  = dwpid_pkg::KD_RIGHT_RST;
    for (int w = 0; w < 2; w++) begin
      integ_st[w]    = 0;
      last_err_st[w] = 0;
    end
  endfunction

  // Register write as the block sees it: narrow fields keep their low bits.
  function automatic void apply_reg(logic [dwpid_pkg::CFG_IDX_W-1:0] idx, logic [23:0] data);
    case (idx)
      dwpid_pkg::REG_TARGET_SPEED: target_q = data[14:0];
      dwpid_pkg::REG_BASE_DUTY:    base_q   = data[15:0];
      dwpid_pkg::REG_KP_LEFT:      kp_q[0]  = data;
      dwpid_pkg::REG_KI_LEFT:      ki_q[0]  = data;
      dwpid_pkg::REG_KD_LEFT:      kd_q[0]  = data;
      dwpid_pkg::REG_KP_RIGHT:     kp_q[1]  = data;
      dwpid_pkg::REG_KI_RIGHT:     ki_q[1]  = data;
      dwpid_pkg::REG_KD_RIGHT:     kd_q[1]  = data;
      default: ;
    endcase
  endfunction

  // One PID step for wheel w, returning the control sum in Q.32.
  function automatic longint wheel_control(int w, int speed);
    int err;
    int deriv;
    int acc;
    if (speed <= 0) begin
      err = 0;
      deriv = 0;
      integ_st[w] = 0;
    end else begin
      err = int'(target_q) - speed;
      acc = integ_st[w] + err;
      if (acc > int'(dwpid_pkg::INT_LIMIT)) acc = int'(dwpid_pkg::INT_LIMIT);
      if (acc < int'(dwpid_pkg::INT_LIMIT_NEG)) acc = int'(dwpid_pkg::INT_LIMIT_NEG);
      integ_st[w] = acc;
      deriv = err - last_err_st[w];
    end
    last_err_st[w] = err;
    return longint'(kp_q[w]) * longint'(err) + longint'(ki_q[w]) * longint'(integ_st[w]) +
           longint'(kd_q[w]) * longint'(deriv);
  endfunction

  // Scale, clamp to the duty window and convert to a compare level.
  function automatic logic [15:0] duty_level(longint control, longint factor);
    longint v;
    longint lo;
    longint hi;
    longint unsigned d;
    v  = (longint'(base_q) * 65536 + control) * factor;
    lo = longint'(dwpid_pkg::DUTY_MIN) * 64'sd4294967296;
    hi = longint'(dwpid_pkg::DUTY_MAX) * 64'sd4294967296;
    if (v < lo) v = lo;
    if (v > hi) v = hi;
    d = longint'(unsigned'(v)) >> 32;
    d = (d * 65535) >> 16;
    return d[15:0];
  endfunction

  function automatic levels_t predict_levels(tick_t t);
    levels_t r;
    longint factor;
    longint cl;
    longint cr;
    r.left  = '0;
    r.right = '0;
    if (t.en) begin
      factor = longint'(dwpid_pkg::FACTOR_ONE);
      if (t.obst < dwpid_pkg::DIST_THRESH) begin
        factor = (longint'(t.obst) * 256) / longint'(dwpid_pkg::DIV_70);
        if (factor < longint'(dwpid_pkg::DUTY_MIN)) factor = longint'(dwpid_pkg::DUTY_MIN);
      end
      cl = wheel_control(0, int'(t.lspd));
      cr = wheel_control(1, int'(t.rspd));
      r.left  = duty_level(cl, factor);
      r.right = duty_level(cr, factor);
    end
    return r;
  endfunction

  function automatic bit idle_now();
    return !no_idle && ($urandom_range(99, 0) < IDLE_PERCENT);
  endfunction

  // Offer one request and record its levels once it has been taken.
  task automatic send_tick(tick_t t);
    @(negedge clk);
    while (idle_now()) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    left_speed        = t.lspd;
    right_speed       = t.rspd;
    obstacle_distance = t.obst;
    control_enable    = t.en;
    in_valid          = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_levels.push_back(predict_levels(t));
  endtask

  task automatic send(int ls, int rs, int obst, bit en);
    tick_t t;
    t.lspd = ls[15:0];
    t.rspd = rs[15:0];
    t.obst = obst[15:0];
    t.en   = en;
    send_tick(t);
  endtask

  // Stop offering requests and let every outstanding result come back.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [dwpid_pkg::CFG_IDX_W-1:0] idx, logic [23:0] data);
    @(negedge clk);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_config(logic [23:0] tgt, logic [23:0] base, logic [23:0] kpl,
                            logic [23:0] kil, logic [23:0] kdl, logic [23:0] kpr,
                            logic [23:0] kir, logic [23:0] kdr);
    drain();
    write_reg(dwpid_pkg::REG_TARGET_SPEED, tgt);
    write_reg(dwpid_pkg::REG_BASE_DUTY, base);
    write_reg(dwpid_pkg::REG_KP_LEFT, kpl);
    write_reg(dwpid_pkg::REG_KI_LEFT, kil);
    write_reg(dwpid_pkg::REG_KD_LEFT, kdl);
    write_reg(dwpid_pkg::REG_KP_RIGHT, kpr);
    write_reg(dwpid_pkg::REG_KI_RIGHT, kir);
    write_reg(dwpid_pkg::REG_KD_RIGHT, kdr);
  endtask

  // Gains spread over many magnitudes rather than bunched near the top.
  function automatic logic [23:0] rand_gain();
    return 24'($urandom) & (24'hFFFFFF >> $urandom_range(23, 0));
  endfunction

  function automatic int near_target(int spread);
    int s;
    s = int'(target_q) + $urandom_range(2 * spread, 0) - spread;
    if (s > 32767) s = 32767;
    if (s < -32768) s = -32768;
    return s;
  endfunction

  function automatic int rand_distance();
    case ($urandom_range(3, 0))
      0: return $urandom_range(17919, 0);
      1: return $urandom_range(65535, 17920);
      2: return $urandom_range(18100, 17700);
      default: return $urandom_range(10800, 10700);
    endcase
  endfunction

  // Mostly running ticks near the set point, with disabled and wild ones mixed in.
  function automatic tick_t rand_tick();
    tick_t t;
    int mode;
    int spread;
    mode   = $urandom_range(99, 0);
    spread = ($urandom_range(3, 0) == 0) ? 8192 : 1024;
    t.lspd = 16'($urandom);
    t.rspd = 16'($urandom);
    t.obst = 16'($urandom);
    t.en   = 1'($urandom_range(1, 0));
    if (mode < 70) begin
      t.lspd = 16'(near_target(spread));
      t.rspd = 16'(near_target(spread));
      t.obst = 16'(rand_distance());
      t.en   = 1'b1;
    end else if (mode < 80) begin
      t.en   = 1'b0;
    end
    return t;
  endfunction

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) send_tick(rand_tick());
  endtask

  // Reset values: the saturating integral, speed clears and the distance bends.
  task automatic test_reset_defaults();
    send(5120, 5120, 65535, 1'b1);
    send(1, 1, 65535, 1'b1);
    repeat (5) send(1, 1, 65535, 1'b1);
    send(0, -32768, 65535, 1'b1);
    send(32767, 32767, 17920, 1'b1);
    send(32767, 32767, 17920, 1'b1);
    send(4000, 6000, 17919, 1'b1);
    send(4000, 6000, 0, 1'b1);
    send(5000, 5300, 10752, 1'b1);
    send(5000, 5300, 10753, 1'b1);
    // Disabled ticks give zero levels and leave the integrals where they were.
    send(-1, 32767, 65535, 1'b0);
    send(0, 0, 0, 1'b0);
    send(4000, 6000, 12000, 1'b1);
    send(-32768, 1, 0, 1'b1);
  endtask

  // Every register at its top value; narrow fields see the upper bits dropped.
  task automatic test_gain_extremes();
    set_config(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
               24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
    send(1, 32767, 65535, 1'b1);
    send(32767, 1, 0, 1'b1);
    send(16384, -5, 17919, 1'b1);
    run_random(150);
  endtask

  // All registers zero: the duty sits at its lower bound.
  task automatic test_zero_config();
    set_config('0, '0, '0, '0, '0, '0, '0, '0);
    send(1, 1, 65535, 1'b1);
    send(32767, -32768, 0, 1'b1);
    run_random(100);
  endtask

  // A run of random register settings, one of them with both sides streaming.
  task automatic test_random_config();
    for (int p = 0; p < 6; p++) begin
      set_config(24'($urandom), 24'($urandom), rand_gain(), rand_gain(), rand_gain(),
                 rand_gain(), rand_gain(), rand_gain());
      no_idle = (p == 2);
      run_random(150);
      no_idle = 1'b0;
    end
  endtask

  // Gains at the reset values, requests offered back to back.
  task automatic test_streaming();
    set_config(24'(dwpid_pkg::TARGET_SPEED_RST), 24'(dwpid_pkg::BASE_DUTY_RST),
               dwpid_pkg::KP_LEFT_RST, dwpid_pkg::KI_LEFT_RST, dwpid_pkg::KD_LEFT_RST,
               dwpid_pkg::KP_RIGHT_RST, dwpid_pkg::KI_RIGHT_RST, dwpid_pkg::KD_RIGHT_RST);
    no_idle = 1'b1;
    run_random(150);
    no_idle = 1'b0;
  endtask

  // The result side stalls at random between the edges.
  always @(negedge clk) begin
    out_stall <= idle_now();
  end

  // Compare each delivered pair of levels with the oldest prediction.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        $error("unexpected result: left_level %0d right_level %0d", left_level,
               right_level);
        mismatches++;
      end else begin
        next_levels = expected_levels.pop_front();
        if (left_level !== next_levels.left) begin
          $error("left_level: expected %0d, actual %0d", next_levels.left, left_level);
          mismatches++;
        end
        if (right_level !== next_levels.right) begin
          $error("right_level: expected %0d, actual %0d", next_levels.right, right_level);
          mismatches++;
        end
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("dual_wheel_pid_duty_controller test failed");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    in_valid          = 1'b0;
    left_speed        = '0;
    right_speed       = '0;
    obstacle_distance = '0;
    control_enable    = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    reset_shadow();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_gain_extremes();
    test_zero_config();
    test_random_config();
    test_streaming();
    drain();

    if (mismatches == 0 && expected_levels.size() == 0) begin
      $display("dual_wheel_pid_duty_controller test passed");
    end else begin
      $display("dual_wheel_pid_duty_controller test failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dwpid_pkg.sv
rtl/dwpid_cfg.sv
rtl/dwpid_datapath.sv
rtl/dwpid_ctrl.sv
rtl/dual_wheel_pid_duty_controller.sv
verif/tb_top.sv
